/* design/hns_pkg.sv */
// Shared types and constants of the height-map normal stream.
`default_nettype none
package hns_pkg;

    // Field widths
    localparam int HEIGHT_W     = 16;
    localparam int CFG_W        = 11;
    localparam int MAX_GRID_DEF = 1024;
    localparam int COORD_W      = 10;
    localparam int NX_W         = 16;
    localparam int NY_W         = 15;

    // Reset value and lower clamp of the grid size register
    localparam logic [CFG_W-1:0] GRID_RESET = 11'd256;
    localparam int               GRID_MIN   = 3;

    // Input word action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    // Normaliser sizes: magnitudes are capped below 2^VEC_W before squaring
    localparam int VEC_W    = 17;
    localparam int SQ_W     = 2 * VEC_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int Q_W      = 15;
    localparam int ROOT_TOP = Q_W - 1;
    localparam int V_SH     = 2 * Q_W;
    localparam int G_SH     = ROOT_TOP + 2;
    localparam int SD_SH    = 2 * ROOT_TOP + 2;
    localparam int ACC_W    = 70;

    // Vector component codes
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic                       action;
        logic signed [HEIGHT_W-1:0] height;
    } sample_t;

    typedef struct packed {
        logic signed [NX_W-1:0] normal_x;
        logic [NY_W-1:0]        normal_y;
        logic signed [NX_W-1:0] normal_z;
        logic [COORD_W-1:0]     cell_column;
        logic [COORD_W-1:0]     cell_row;
        logic                   frame_end;
    } normal_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_RD_A,
        OP_RD_B,
        OP_RD_C,
        OP_WR,
        OP_VEC,
        OP_SHIFT,
        OP_SQ,
        OP_SUM,
        OP_ROOT,
        OP_LOAD
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               take;
        logic               wr_en;
        logic               flush;
        logic               has_left;
        logic               has_right;
        logic               has_up;
        logic               has_down;
        logic [1:0]         comp;
        logic [3:0]         bit_idx;
        logic               first;
        logic               last;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic               out_end;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* design/hns_datapath.sv */
// Datapath: line stores, neighbor sums, squaring, bit-serial normaliser, output register.
`default_nettype none
module hns_datapath import hns_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF,
    localparam int CW = $clog2(MAX_GRID)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cmd_t                       cmd,
    input  wire logic [CW-1:0]              cell_addr,
    input  wire logic signed [HEIGHT_W-1:0] height,
    output status_t                         status,
    output logic                            normal_valid,
    input  wire logic                       normal_stall,
    output normal_t                         normal
);

    localparam int DW = HEIGHT_W + 2;

    // Line stores and their registered read data
    logic signed [HEIGHT_W-1:0] mem_new [MAX_GRID];
    logic signed [HEIGHT_W-1:0] mem_old [MAX_GRID];
    logic signed [HEIGHT_W-1:0] n_rdata_reg, o_rdata_reg;
    logic [CW-1:0]              n_addr, o_addr, addr_inc, addr_dec;

    // Captured neighborhood
    logic signed [HEIGHT_W-1:0] h_reg, ctr_reg, up_reg, right_reg, lold_reg, lnew_reg;

    // Vector magnitudes and signs
    logic [DW-1:0] ax_reg, ay_reg, az_reg;
    logic          xneg_reg, zneg_reg;

    // Normaliser state
    logic [SQ_W-1:0]              sq_reg [3];
    logic [SUM_W-1:0]             s_reg;
    logic signed [ACC_W-1:0]      w_reg, g_reg, sd_reg;
    logic [Q_W-1:0]               q_reg;
    logic [Q_W-1:0]               qres_reg [3];
    logic                         out_valid_reg;
    normal_t                      out_reg;

    // Store addresses
    always_comb
    begin
        addr_inc = cell_addr + CW'(1);
        addr_dec = cell_addr - CW'(1);
        n_addr   = cell_addr;
        o_addr   = cell_addr;
        if (cmd.op == OP_RD_B)
        begin
            n_addr = addr_inc;
            o_addr = addr_dec;
        end
        else if (cmd.op == OP_RD_C)
        begin
            n_addr = addr_dec;
        end
    end

    // Line stores: older row takes the retiring newer entry
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WR && cmd.wr_en)
        begin
            mem_old[cell_addr] <= ctr_reg;
            mem_new[cell_addr] <= h_reg;
        end
        n_rdata_reg <= mem_new[n_addr];
        o_rdata_reg <= mem_old[o_addr];
    end

    // Neighbor sums
    logic signed [DW-1:0] lft, dx_l, dx_r, dz_u, dz_d, x_sum, z_sum;
    logic [2:0]           cnt;
    always_comb
    begin
        lft   = cmd.flush ? DW'(lnew_reg) : DW'(lold_reg);
        dx_l  = cmd.has_left  ? lft - DW'(ctr_reg) : '0;
        dx_r  = cmd.has_right ? DW'(ctr_reg) - DW'(right_reg) : '0;
        dz_u  = cmd.has_up    ? DW'(up_reg) - DW'(ctr_reg) : '0;
        dz_d  = cmd.has_down  ? DW'(ctr_reg) - DW'(h_reg) : '0;
        x_sum = dx_l + dx_r;
        z_sum = dz_u + dz_d;
        cnt   = 3'(cmd.has_left) + 3'(cmd.has_right) + 3'(cmd.has_up) + 3'(cmd.has_down);
    end

    // Scale-down amount so the largest magnitude fits VEC_W bits
    logic [DW-1:0] or_mag;
    logic [4:0]    sh;
    always_comb
    begin
        or_mag = ax_reg | ay_reg | az_reg;
        sh     = '0;
        for (int i = VEC_W; i < DW; i++)
        begin
            if (or_mag[i])
            begin
                sh = 5'(i - VEC_W + 1);
            end
        end
    end

    // Square selection
    logic [VEC_W-1:0] v_sel;
    always_comb
    begin
        unique case (cmd.comp)
            COMP_X:  v_sel = VEC_W'(ax_reg);
            COMP_Y:  v_sel = VEC_W'(ay_reg);
            default: v_sel = VEC_W'(az_reg);
        endcase
    end

    // One bit of the rounded root: largest q with (2q-1)^2 * S <= v^2 * 2^30
    logic [SUM_W-1:0]        s_eff;
    logic signed [ACC_W-1:0] s_ext, cur_w, cur_g, cur_sd, w_try, v2;
    logic [Q_W-1:0]          cur_q, q_next;
    logic                    ok;
    always_comb
    begin
        s_eff  = (s_reg == '0) ? SUM_W'(1) : s_reg;
        s_ext  = signed'(ACC_W'(s_eff));
        cur_w  = cmd.first ? s_ext : w_reg;
        cur_g  = cmd.first ? -(s_ext <<< G_SH) : g_reg;
        cur_sd = cmd.first ? (s_ext <<< SD_SH) : sd_reg;
        cur_q  = cmd.first ? '0 : q_reg;
        v2     = signed'(ACC_W'(sq_reg[cmd.comp]) << V_SH);
        w_try  = cur_w + cur_g + cur_sd;
        ok     = (w_try <= v2);
        q_next = ok ? (cur_q | (Q_W'(1) << cmd.bit_idx)) : cur_q;
    end

    // Signed output parts
    logic [NX_W-1:0] qx16, qz16;
    always_comb
    begin
        qx16 = NX_W'(qres_reg[COMP_X]);
        qz16 = NX_W'(qres_reg[COMP_Z]);
        if (xneg_reg) qx16 = NX_W'(0) - qx16;
        if (zneg_reg) qz16 = NX_W'(0) - qz16;
    end

    // Arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            h_reg <= height;
        end
        unique case (cmd.op)
            OP_RD_B:
            begin
                ctr_reg <= n_rdata_reg;
                up_reg  <= o_rdata_reg;
            end
            OP_RD_C:
            begin
                right_reg <= n_rdata_reg;
                lold_reg  <= o_rdata_reg;
            end
            OP_WR:
            begin
                lnew_reg <= n_rdata_reg;
            end
            OP_VEC:
            begin
                ax_reg   <= x_sum[DW-1] ? DW'(-x_sum) : DW'(x_sum);
                az_reg   <= z_sum[DW-1] ? DW'(-z_sum) : DW'(z_sum);
                ay_reg   <= DW'(cnt) << 8;
                xneg_reg <= x_sum[DW-1];
                zneg_reg <= z_sum[DW-1];
            end
            OP_SHIFT:
            begin
                ax_reg <= ax_reg >> sh;
                ay_reg <= ay_reg >> sh;
                az_reg <= az_reg >> sh;
            end
            OP_SQ:
            begin
                sq_reg[cmd.comp] <= SQ_W'(v_sel * v_sel);
            end
            OP_SUM:
            begin
                s_reg <= SUM_W'(sq_reg[COMP_X]) + SUM_W'(sq_reg[COMP_Y])
                       + SUM_W'(sq_reg[COMP_Z]);
            end
            OP_ROOT:
            begin
                w_reg  <= ok ? w_try : cur_w;
                g_reg  <= ok ? (cur_g >>> 1) + cur_sd : (cur_g >>> 1);
                sd_reg <= cur_sd >>> 2;
                q_reg  <= q_next;
                if (cmd.last)
                begin
                    qres_reg[cmd.comp] <= q_next;
                end
            end
            OP_LOAD:
            begin
                out_reg.normal_x    <= qx16;
                out_reg.normal_y    <= qres_reg[COMP_Y];
                out_reg.normal_z    <= qz16;
                out_reg.cell_column <= cmd.out_col;
                out_reg.cell_row    <= cmd.out_row;
                out_reg.frame_end   <= cmd.out_end;
            end
            default:
            begin
            end
        endcase
    end

    // Output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!normal_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || !normal_stall;
    assign normal_valid    = out_valid_reg;
    assign normal          = out_reg;

endmodule
`default_nettype wire

/* design/hns_ctrl.sv */
// Controller: frame counters, grid size register and the per-word sequencer.
`default_nettype none
module hns_ctrl import hns_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF,
    localparam int CW = $clog2(MAX_GRID),
    localparam int SW = $clog2(MAX_GRID + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             sample_valid,
    input  wire logic             sample_action,
    output logic                  sample_stall,
    input  wire status_t          status,
    output cmd_t                  cmd,
    output logic [CW-1:0]         cell_addr
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_WR,
        S_VEC,
        S_SHIFT,
        S_SQ,
        S_SUM,
        S_ROOT,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   grid_reg;
    logic [CW-1:0]      col_reg, fcol_reg, cur_col_reg;
    logic [SW-1:0]      row_reg;
    logic               flush_reg, emit_reg, end_reg;
    logic               hl_reg, hr_reg, hu_reg, hd_reg;
    logic [COORD_W-1:0] out_row_reg, out_col_reg;
    logic [1:0]         comp_reg;
    logic [3:0]         bit_reg;

    // Effective grid size and neighbor tests
    logic [SW-1:0] size, col_inc, fcol_inc;
    always_comb
    begin
        if (grid_reg < CFG_W'(GRID_MIN))
        begin
            size = SW'(GRID_MIN);
        end
        else if (32'(grid_reg) > MAX_GRID)
        begin
            size = SW'(MAX_GRID);
        end
        else
        begin
            size = SW'(grid_reg);
        end
        col_inc  = SW'(col_reg) + SW'(1);
        fcol_inc = SW'(fcol_reg) + SW'(1);
    end

    // Sequencer and frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            grid_reg    <= GRID_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            fcol_reg    <= '0;
            cur_col_reg <= '0;
            flush_reg   <= 1'b0;
            emit_reg    <= 1'b0;
            end_reg     <= 1'b0;
            hl_reg      <= 1'b0;
            hr_reg      <= 1'b0;
            hu_reg      <= 1'b0;
            hd_reg      <= 1'b0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            comp_reg    <= COMP_X;
            bit_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        // new grid size starts a new frame
                        grid_reg <= cfg_data;
                        col_reg  <= '0;
                        row_reg  <= '0;
                        fcol_reg <= '0;
                    end
                    else if (sample_valid)
                    begin
                        if (sample_action == ACT_SAMPLE && row_reg < size)
                        begin
                            cur_col_reg <= col_reg;
                            flush_reg   <= 1'b0;
                            hl_reg      <= (col_reg != '0);
                            hr_reg      <= (col_inc < size);
                            hu_reg      <= (row_reg >= SW'(2));
                            hd_reg      <= 1'b1;
                            emit_reg    <= (row_reg != '0);
                            out_row_reg <= COORD_W'(row_reg - SW'(1));
                            out_col_reg <= COORD_W'(col_reg);
                            end_reg     <= 1'b0;
                            state_reg   <= S_RD_A;
                        end
                        else if (sample_action == ACT_FLUSH && row_reg >= size)
                        begin
                            cur_col_reg <= fcol_reg;
                            flush_reg   <= 1'b1;
                            hl_reg      <= (fcol_reg != '0);
                            hr_reg      <= (fcol_inc < size);
                            hu_reg      <= 1'b1;
                            hd_reg      <= 1'b0;
                            emit_reg    <= 1'b1;
                            out_row_reg <= COORD_W'(size - SW'(1));
                            out_col_reg <= COORD_W'(fcol_reg);
                            end_reg     <= (fcol_inc == size);
                            state_reg   <= S_RD_A;
                        end
                    end
                end
                S_RD_A:  state_reg <= S_RD_B;
                S_RD_B:  state_reg <= S_RD_C;
                S_RD_C:  state_reg <= S_WR;
                S_WR:
                begin
                    if (!flush_reg)
                    begin
                        if (col_inc >= size)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + SW'(1);
                        end
                        else
                        begin
                            col_reg <= CW'(col_inc);
                        end
                    end
                    else if (end_reg)
                    begin
                        fcol_reg <= '0;
                        col_reg  <= '0;
                        row_reg  <= '0;
                    end
                    else
                    begin
                        fcol_reg <= CW'(fcol_inc);
                    end
                    state_reg <= emit_reg ? S_VEC : S_IDLE;
                end
                S_VEC:   state_reg <= S_SHIFT;
                S_SHIFT:
                begin
                    comp_reg  <= COMP_X;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (comp_reg == COMP_Z)
                    begin
                        state_reg <= S_SUM;
                    end
                    comp_reg <= comp_reg + 2'd1;
                end
                S_SUM:
                begin
                    comp_reg  <= COMP_X;
                    bit_reg   <= 4'(ROOT_TOP);
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (bit_reg == '0)
                    begin
                        bit_reg <= 4'(ROOT_TOP);
                        if (comp_reg == COMP_Z)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 4'd1;
                    end
                end
                S_DONE:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Commands to the datapath
    always_comb
    begin
        unique case (state_reg)
            S_RD_A:  cmd.op = OP_RD_A;
            S_RD_B:  cmd.op = OP_RD_B;
            S_RD_C:  cmd.op = OP_RD_C;
            S_WR:    cmd.op = OP_WR;
            S_VEC:   cmd.op = OP_VEC;
            S_SHIFT: cmd.op = OP_SHIFT;
            S_SQ:    cmd.op = OP_SQ;
            S_SUM:   cmd.op = OP_SUM;
            S_ROOT:  cmd.op = OP_ROOT;
            S_DONE:  cmd.op = status.out_free ? OP_LOAD : OP_IDLE;
            default: cmd.op = OP_IDLE;
        endcase
        cmd.take      = (state_reg == S_IDLE) && sample_valid && !cfg_valid;
        cmd.wr_en     = !flush_reg;
        cmd.flush     = flush_reg;
        cmd.has_left  = hl_reg;
        cmd.has_right = hr_reg;
        cmd.has_up    = hu_reg;
        cmd.has_down  = hd_reg;
        cmd.comp      = comp_reg;
        cmd.bit_idx   = bit_reg;
        cmd.first     = (bit_reg == 4'(ROOT_TOP));
        cmd.last      = (bit_reg == '0);
        cmd.out_col   = out_col_reg;
        cmd.out_row   = out_row_reg;
        cmd.out_end   = end_reg;
    end

    assign cell_addr    = cur_col_reg;
    assign cfg_ready    = (state_reg == S_IDLE);
    assign sample_stall = (state_reg != S_IDLE) || cfg_valid;

endmodule
`default_nettype wire

/* design/heightmap_normal_stream.sv */
// Top level of the height-map normal stream: controller, datapath and checks.
//
// Heights of a square grid arrive in raster order on the sample channel; each
// word after the first row yields one unit normal (signed Q1.14) for the cell one
// row above, and once all rows are in, flush words yield the last row one cell
// each, the final one marked with frame_end. A word that produces a normal goes
// through the line-store reads and update, forming and scaling the vector,
// squaring and summing, the bit-serial rounded-root unit (15 bits for each of
// three parts through one shared add-and-compare), and the output register
// load. First-row samples pass only the reads and update. A finished normal
// waits in the output register while the next word is being worked on.
// A grid_size write clears the row, column and flush counters.
`default_nettype none
module heightmap_normal_stream import hns_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             sample_valid,
    output logic                  sample_stall,
    input  wire sample_t          sample,
    output logic                  normal_valid,
    input  wire logic             normal_stall,
    output normal_t               normal
);

    localparam int CW = $clog2(MAX_GRID);

    cmd_t          cmd;
    status_t       status;
    logic [CW-1:0] cell_addr;

    hns_ctrl #(
        .MAX_GRID(MAX_GRID)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_action(sample.action),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd),
        .cell_addr    (cell_addr)
    );

    hns_datapath #(
        .MAX_GRID(MAX_GRID)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cell_addr   (cell_addr),
        .height      (sample.height),
        .status      (status),
        .normal_valid(normal_valid),
        .normal_stall(normal_stall),
        .normal      (normal)
    );

    // A configuration write and a sample word never land on the same edge
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && sample_valid && !sample_stall))
        else $error("config write and sample word accepted together");

    // The y part of a unit normal never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        normal_valid |-> (normal.normal_y <= 15'd16384))
        else $error("normal_y above one");

    // A new normal only appears after the sequencer was busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(normal_valid) |-> $past(sample_stall))
        else $error("normal produced without work in progress");

endmodule
`default_nettype wire
